@@ hdl/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared constants, controller states and command/status types for the rod
// bending curvature block.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COMP_WIDTH_DEF = 24;

  localparam int CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] CHI_FLOOR_RESET = 16'd16;

  // tangent normalization window: largest magnitude lands in [2^29, 2^30)
  localparam int NORM_BITS         = 30;
  localparam int NORM_LO_EXP       = 29;
  localparam int NORM_COARSE_EXP   = 21;
  localparam int NORM_COARSE_SHIFT = 8;

  localparam int SQ_BITS    = 62;
  localparam int ROOT_BITS  = 31;
  localparam int SQRT_STEPS = 31;
  localparam int DEN_BITS   = 31;
  localparam int ACC_BITS   = 64;
  localparam int MUL_A_BITS = 31;

  localparam int KB_BITS = 29;
  localparam logic [KB_BITS-1:0] KB_LIMIT = 29'h0FFF_FFFF;

  localparam int NUM_SLOTS = 7;
  localparam logic [2:0] SLOT_N0   = 3'd0;
  localparam logic [2:0] SLOT_N1   = 3'd1;
  localparam logic [2:0] SLOT_N2   = 3'd2;
  localparam logic [2:0] SLOT_M1E  = 3'd3;
  localparam logic [2:0] SLOT_M2E  = 3'd4;
  localparam logic [2:0] SLOT_M1F  = 3'd5;
  localparam logic [2:0] SLOT_M2F  = 3'd6;
  localparam logic [2:0] SLOT_NONE = 3'd7;

  typedef enum logic [2:0] {
    SEL_SQ,
    SEL_DOT,
    SEL_CRA,
    SEL_CRB,
    SEL_K1,
    SEL_K2
  } rbc_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ZCHK,
    ST_NORM,
    ST_SQ,
    ST_SQI,
    ST_SQRT,
    ST_DINI,
    ST_DIV,
    ST_DST,
    ST_DOT,
    ST_CHK,
    ST_CRS,
    ST_KDI,
    ST_K1,
    ST_K1S,
    ST_K2,
    ST_OUT
  } rbc_state_t;

  typedef struct packed {
    logic       start;
    logic       load_edge;
    logic       edge_sel;
    logic       norm_step;
    logic       acc_clr;
    logic       mac;
    logic       mac_sub;
    rbc_sel_t   sel;
    logic [1:0] idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_kb;
    logic       div_step;
    logic       div_store;
    logic       chi_latch;
    logic       deg_set;
    logic       k1_latch;
    logic       out_load;
  } rbc_cmd_t;

  typedef struct packed {
    logic edge_zero;
    logic norm_done;
    logic chi_low;
  } rbc_stat_t;

endpackage

@@ hdl/rod_bend_curvature.sv @@
// ----------------------------------------------------------------------------
// rod_bend_curvature
// Bending curvature of one bend-twist spring of a discrete elastic rod.
// ----------------------------------------------------------------------------
// Loads go to slots 0 to 5; a word for slot 7 is dropped. The final slot (6)
// starts the evaluation, which runs on the single shared restoring divider,
// one quotient bit a cycle, used for six tangent components and three
// binormal components, plus a 31-step square root per edge. Loads may
// continue while a finished word waits on the output; a new final slot
// waits until that word is taken.
module rod_bend_curvature
  import rbc_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_WIDTH-1:0]         cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   op,
  input  logic signed [COMP_WIDTH-1:0] comp_x,
  input  logic signed [COMP_WIDTH-1:0] comp_y,
  input  logic signed [COMP_WIDTH-1:0] comp_z,
  input  logic                         negate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] bend_k1,
  output logic signed [COMP_WIDTH-1:0] bend_k2,
  output logic                         degenerate
);

  logic [CFG_WIDTH-1:0] chi_floor;
  logic                 in_fire;
  rbc_cmd_t             cmd;
  rbc_stat_t            stat;

  always_ff @(posedge clk) begin
    if (rst)         chi_floor <= CHI_FLOOR_RESET;
    else if (cfg_we) chi_floor <= cfg_wdata;
  end

  rbc_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .out_ready(out_ready),
    .stat     (stat),
    .in_ready (in_ready),
    .in_fire  (in_fire),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  rbc_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .COMP_WIDTH(COMP_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .op        (op),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .comp_z    (comp_z),
    .negate    (negate),
    .chi_floor (chi_floor),
    .cmd       (cmd),
    .stat      (stat),
    .bend_k1   (bend_k1),
    .bend_k2   (bend_k2),
    .degenerate(degenerate)
  );

endmodule

@@ hdl/rbc_datapath.sv @@
// ----------------------------------------------------------------------------
// rbc_datapath
// Vector store, edge normalizer, shared multiplier/accumulator, restoring
// square root and divider, and the result registers.
// ----------------------------------------------------------------------------
module rbc_datapath
  import rbc_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic [2:0]                   op,
  input  logic signed [COMP_WIDTH-1:0] comp_x,
  input  logic signed [COMP_WIDTH-1:0] comp_y,
  input  logic signed [COMP_WIDTH-1:0] comp_z,
  input  logic                         negate,
  input  logic [CFG_WIDTH-1:0]         chi_floor,
  input  rbc_cmd_t                     cmd,
  output rbc_stat_t                    stat,
  output logic signed [COMP_WIDTH-1:0] bend_k1,
  output logic signed [COMP_WIDTH-1:0] bend_k2,
  output logic                         degenerate
);

  localparam int F   = FRAC_BITS;
  localparam int W   = COMP_WIDTH;
  localparam int EW  = W + 1;
  localparam int MW  = (W + 1 > NORM_BITS + 1) ? W + 1 : NORM_BITS + 1;
  localparam int TW  = F + 2;
  localparam int DVW = NORM_BITS + F;
  localparam int MBW = (W + 1 > MUL_A_BITS) ? W + 1 : MUL_A_BITS;
  localparam int PW  = MUL_A_BITS + MBW;
  localparam int UP  = (F >= 16) ? F - 16 : 0;
  localparam int DN  = (F < 16) ? 16 - F : 0;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] LO_B = MW'(1) << NORM_LO_EXP;
  localparam logic [MW-1:0] HI_B = MW'(1) << NORM_BITS;
  localparam logic [MW-1:0] CO_B = MW'(1) << NORM_COARSE_EXP;

  function automatic logic signed [W-1:0] sat_w(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'(CMAX);
    lo = ACC_BITS'(CMIN);
    if (v > hi) return CMAX;
    if (v < lo) return CMIN;
    return v[W-1:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    unique case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // ---------------- vector store ----------------
  logic signed [W-1:0] vec [NUM_SLOTS][3];
  logic signed [W-1:0] in_v [3];
  logic signed [W-1:0] ld_v [3];
  logic                flip;

  assign in_v[0] = comp_x;
  assign in_v[1] = comp_y;
  assign in_v[2] = comp_z;
  assign flip = negate && (op == SLOT_M2E || op == SLOT_M2F);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flip) ld_v[i] = (in_v[i] == CMIN) ? CMAX : -in_v[i];
      else      ld_v[i] = in_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && op != SLOT_NONE) begin
      for (int i = 0; i < 3; i++) vec[op][i] <= ld_v[i];
    end
  end

  // ---------------- edge, magnitude, normalize ----------------
  logic signed [EW-1:0] ed_sel [3];
  logic [EW-1:0]        ed_abs [3];
  logic [MW-1:0]        mag [3];
  logic                 sgn [3];
  logic [MW-1:0]        mx;
  logic                 need_left, need_right, coarse;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.edge_sel)
        ed_sel[i] = EW'(vec[2][i]) - EW'(vec[1][i]);
      else
        ed_sel[i] = EW'(vec[1][i]) - EW'(vec[0][i]);
      ed_abs[i] = ed_sel[i][EW-1] ? EW'(-ed_sel[i]) : EW'(ed_sel[i]);
    end
  end

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  assign need_left  = mx < LO_B;
  assign need_right = mx >= HI_B;
  assign coarse     = mx < CO_B;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.load_edge) begin
        mag[i] <= MW'(ed_abs[i]);
        sgn[i] <= ed_sel[i][EW-1];
      end else if (cmd.norm_step) begin
        if (need_right)  mag[i] <= mag[i] >> 1;
        else if (coarse) mag[i] <= mag[i] << NORM_COARSE_SHIFT;
        else             mag[i] <= mag[i] << 1;
      end
    end
  end

  // ---------------- multiply / accumulate ----------------
  logic signed [TW-1:0]      te [3];
  logic signed [TW-1:0]      tf [3];
  logic signed [KB_BITS-1:0] kb [3];
  logic signed [EW-1:0]      sum1 [3];
  logic signed [EW-1:0]      sum2 [3];
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MBW-1:0]        mul_b;
  logic signed [PW-1:0]         prod;
  logic                         pend_add, pend_sub;
  logic signed [ACC_BITS-1:0]   acc;
  logic [1:0]                   ia, ib;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum1[i] = EW'(vec[4][i]) + EW'(vec[6][i]);
      sum2[i] = EW'(vec[3][i]) + EW'(vec[5][i]);
    end
  end

  assign ia = nxt3(cmd.idx);
  assign ib = nxt3(ia);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      SEL_SQ: begin
        mul_a = $signed({1'b0, mag[cmd.idx][NORM_BITS-1:0]});
        mul_b = MBW'($signed({1'b0, mag[cmd.idx][NORM_BITS-1:0]}));
      end
      SEL_DOT: begin
        mul_a = MUL_A_BITS'(te[cmd.idx]);
        mul_b = MBW'(tf[cmd.idx]);
      end
      SEL_CRA: begin
        mul_a = MUL_A_BITS'(te[ia]);
        mul_b = MBW'(tf[ib]);
      end
      SEL_CRB: begin
        mul_a = MUL_A_BITS'(te[ib]);
        mul_b = MBW'(tf[ia]);
      end
      SEL_K1: begin
        mul_a = MUL_A_BITS'(kb[cmd.idx]);
        mul_b = MBW'(sum1[cmd.idx]);
      end
      SEL_K2: begin
        mul_a = MUL_A_BITS'(kb[cmd.idx]);
        mul_b = MBW'(sum2[cmd.idx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_add <= 1'b0;
      pend_sub <= 1'b0;
    end else begin
      pend_add <= cmd.mac && !cmd.mac_sub;
      pend_sub <= cmd.mac && cmd.mac_sub;
    end
  end

  // the product is registered with its add/subtract flag, then accumulated
  always_ff @(posedge clk) begin
    if (cmd.acc_clr)   acc <= '0;
    else if (pend_add) acc <= acc + ACC_BITS'(prod);
    else if (pend_sub) acc <= acc - ACC_BITS'(prod);
  end

  // ---------------- square root, two bits a step ----------------
  logic [SQ_BITS-1:0]   sq_x;
  logic [ROOT_BITS+1:0] sq_r;
  logic [ROOT_BITS-1:0] root;
  logic [ROOT_BITS+3:0] sq_rt, sq_trial;

  assign sq_rt    = {sq_r, sq_x[SQ_BITS-1 -: 2]};
  assign sq_trial = (ROOT_BITS + 4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_x <= acc[SQ_BITS-1:0];
      sq_r <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_x <= sq_x << 2;
      if (sq_rt >= sq_trial) begin
        sq_r <= (ROOT_BITS + 2)'(sq_rt - sq_trial);
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        sq_r <= sq_rt[ROOT_BITS+1:0];
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // ---------------- restoring divider ----------------
  logic [DVW-1:0]        dv_n;
  logic [DEN_BITS-1:0]   dv_d;
  logic [DEN_BITS:0]     dv_r;
  logic [DEN_BITS+1:0]   dv_rt;
  logic                  dv_ge, dv_sign;
  logic [DEN_BITS-1:0]   chi;
  logic [ACC_BITS-1:0]   cr_abs;
  logic [TW-1:0]         tq;
  logic [KB_BITS-1:0]    kq;

  assign dv_rt  = {dv_r, dv_n[DVW-1]};
  assign dv_ge  = dv_rt >= (DEN_BITS + 2)'(dv_d);
  assign cr_abs = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dv_r <= '0;
      if (cmd.div_kb) begin
        dv_n    <= DVW'(cr_abs << 1);
        dv_d    <= chi;
        dv_sign <= acc[ACC_BITS-1];
      end else begin
        dv_n    <= {mag[cmd.idx][NORM_BITS-1:0], {F{1'b0}}};
        dv_d    <= root;
        dv_sign <= sgn[cmd.idx];
      end
    end else if (cmd.div_step) begin
      dv_r <= dv_ge ? (DEN_BITS + 1)'(dv_rt - (DEN_BITS + 2)'(dv_d)) : dv_rt[DEN_BITS:0];
      dv_n <= {dv_n[DVW-2:0], dv_ge};
    end
  end

  assign tq = dv_n[TW-1:0];
  assign kq = (dv_n > DVW'(KB_LIMIT)) ? KB_LIMIT : dv_n[KB_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (cmd.div_kb)
        kb[cmd.idx] <= dv_sign ? -$signed(kq) : $signed(kq);
      else if (cmd.edge_sel)
        tf[cmd.idx] <= dv_sign ? -$signed(tq) : $signed(tq);
      else
        te[cmd.idx] <= dv_sign ? -$signed(tq) : $signed(tq);
    end
  end

  // ---------------- chi and threshold ----------------
  logic signed [ACC_BITS-1:0] chi_w;
  logic [ACC_BITS-1:0]        thr_w;

  assign chi_w = (ACC_BITS'(1) << F) + (acc >>> F);
  assign thr_w = (ACC_BITS'(chi_floor) << UP) >> DN;

  always_ff @(posedge clk) begin
    if (cmd.chi_latch) chi <= chi_w[DEN_BITS-1:0];
  end

  assign stat.edge_zero = (mx == '0);
  assign stat.norm_done = !need_left && !need_right;
  assign stat.chi_low   = chi_w <= $signed(thr_w);

  // ---------------- results ----------------
  logic signed [W-1:0]        k1r;
  logic signed [ACC_BITS-1:0] acc_neg;

  assign acc_neg = -acc;

  always_ff @(posedge clk) begin
    if (rst)            degenerate <= 1'b0;
    else if (cmd.start) degenerate <= 1'b0;
    else if (cmd.deg_set) degenerate <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.k1_latch) k1r <= sat_w(acc >>> (F + 1));
    if (cmd.out_load) begin
      bend_k1 <= degenerate ? '0 : k1r;
      bend_k2 <= degenerate ? '0 : sat_w(acc_neg >>> (F + 1));
    end
  end

endmodule

@@ hdl/rbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbc_ctrl
// Sequencer for the curvature evaluation: steps the datapath through edges,
// normalization, square root, divisions, and the cross and dot products.
// ----------------------------------------------------------------------------
module rbc_ctrl
  import rbc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] op,
  input  logic       out_ready,
  input  rbc_stat_t  stat,
  output logic       in_ready,
  output logic       in_fire,
  output logic       out_valid,
  output rbc_cmd_t   cmd
);

  localparam int DIV_STEPS = NORM_BITS + FRAC_BITS;
  localparam int CNTW      = $clog2(DIV_STEPS);

  rbc_state_t      state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [1:0]      comp, comp_next;
  logic            edge_q, edge_next;
  logic            kbmode, kbmode_next;

  assign in_ready = (state == ST_IDLE) && (!out_valid || op != SLOT_M2F);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      comp   <= '0;
      edge_q <= 1'b0;
      kbmode <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      comp   <= comp_next;
      edge_q <= edge_next;
      kbmode <= kbmode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    comp_next   = comp;
    edge_next   = edge_q;
    kbmode_next = kbmode;
    cmd         = '0;
    cmd.edge_sel = edge_q;
    cmd.idx      = comp;

    unique case (state)
      ST_IDLE: begin
        if (in_fire && op == SLOT_M2F) begin
          cmd.start  = 1'b1;
          edge_next  = 1'b0;
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.load_edge = 1'b1;
        state_next    = ST_ZCHK;
      end
      ST_ZCHK: begin
        if (stat.edge_zero) begin
          cmd.deg_set = 1'b1;
          state_next  = ST_OUT;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.norm_done) begin
          cnt_next   = '0;
          state_next = ST_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQ: begin
        cmd.acc_clr = (cnt == '0);
        cmd.sel     = SEL_SQ;
        cmd.idx     = cnt[1:0];
        if (cnt < CNTW'(3)) begin
          cmd.mac  = 1'b1;
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = ST_SQI;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == CNTW'(SQRT_STEPS - 1)) begin
          comp_next   = '0;
          kbmode_next = 1'b0;
          state_next  = ST_DINI;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DINI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(DIV_STEPS - 1)) state_next = ST_DST;
        else                             cnt_next   = cnt + 1'b1;
      end
      ST_DST: begin
        cmd.div_store = 1'b1;
        cmd.div_kb    = kbmode;
        cnt_next      = '0;
        if (comp != 2'd2) begin
          comp_next  = comp + 1'b1;
          state_next = kbmode ? ST_CRS : ST_DINI;
        end else if (kbmode) begin
          state_next = ST_K1;
        end else if (!edge_q) begin
          edge_next  = 1'b1;
          comp_next  = '0;
          state_next = ST_EDGE;
        end else begin
          state_next = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd.acc_clr = (cnt == '0);
        cmd.sel     = SEL_DOT;
        cmd.idx     = cnt[1:0];
        if (cnt < CNTW'(3)) begin
          cmd.mac  = 1'b1;
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chi_latch = 1'b1;
        if (stat.chi_low) begin
          cmd.deg_set = 1'b1;
          state_next  = ST_OUT;
        end else begin
          comp_next   = '0;
          cnt_next    = '0;
          kbmode_next = 1'b1;
          state_next  = ST_CRS;
        end
      end
      ST_CRS: begin
        // cross component: a*b, minus the swapped product, then drain
        cmd.acc_clr = (cnt == '0);
        cmd.idx     = comp;
        if (cnt == '0) begin
          cmd.mac  = 1'b1;
          cmd.sel  = SEL_CRA;
          cnt_next = cnt + 1'b1;
        end else if (cnt == CNTW'(1)) begin
          cmd.mac     = 1'b1;
          cmd.mac_sub = 1'b1;
          cmd.sel     = SEL_CRB;
          cnt_next    = cnt + 1'b1;
        end else begin
          state_next = ST_KDI;
        end
      end
      ST_KDI: begin
        cmd.div_init = 1'b1;
        cmd.div_kb   = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_K1: begin
        cmd.acc_clr = (cnt == '0);
        cmd.sel     = SEL_K1;
        cmd.idx     = cnt[1:0];
        if (cnt < CNTW'(3)) begin
          cmd.mac  = 1'b1;
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = ST_K1S;
        end
      end
      ST_K1S: begin
        cmd.k1_latch = 1'b1;
        cnt_next     = '0;
        state_next   = ST_K2;
      end
      ST_K2: begin
        cmd.acc_clr = (cnt == '0);
        cmd.sel     = SEL_K2;
        cmd.idx     = cnt[1:0];
        if (cnt < CNTW'(3)) begin
          cmd.mac  = 1'b1;
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result register overwritten while a word is pending");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == SLOT_M2F) |=> state == ST_EDGE)
    else $error("final slot did not start evaluation");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT |-> cnt < CNTW'(SQRT_STEPS))
    else $error("square root step count overrun");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside output state");

endmodule

@@ tb/sv/rod_bend_curvature_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_bend_curvature_checker
// Watches the load and result channels of the rod bending curvature block,
// keeps a bit-exact fixed-point model of the spring, and compares every
// result word field by field against the oldest predicted curvature.
// ----------------------------------------------------------------------------
module rod_bend_curvature_checker
  import rbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_WIDTH-1:0]  cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            op,
  input  logic signed [23:0]    comp_x,
  input  logic signed [23:0]    comp_y,
  input  logic signed [23:0]    comp_z,
  input  logic                  negate,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [23:0]    bend_k1,
  input  logic signed [23:0]    bend_k2,
  input  logic                  degenerate,
  output int                    errors,
  output int                    pending
);

  localparam longint unsigned WIN_LO = 64'd1 << 29;
  localparam longint unsigned WIN_HI = 64'd1 << 30;
  localparam longint KB_MAX = 64'd268435455;
  localparam longint ONE_Q = 64'd65536;

  typedef struct packed {
    logic [23:0] k1;
    logic [23:0] k2;
    logic        deg;
  } curv_t;

  curv_t          curv_q[$];
  longint         vec_mem [0:5][0:2];
  logic [15:0]    floor_reg;

  assign pending = curv_q.size();

  function automatic longint sat_q(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit direction in Q16; 0 for a zero-length edge
  function automatic bit unit_dir(input longint dx, dy, dz,
                                  output longint tx, ty, tz);
    longint unsigned mx, my, mz, top, nrm;
    mx = dx < 0 ? longint'(-dx) : dx;
    my = dy < 0 ? longint'(-dy) : dy;
    mz = dz < 0 ? longint'(-dz) : dz;
    tx = 0; ty = 0; tz = 0;
    top = mx;
    if (my > top) top = my;
    if (mz > top) top = mz;
    if (top == 0) return 1'b0;
    while (top < WIN_LO) begin
      top <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
    end
    while (top >= WIN_HI) begin
      top >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
    end
    nrm = root_floor(mx * mx + my * my + mz * mz);
    tx = longint'((mx << 16) / nrm);
    ty = longint'((my << 16) / nrm);
    tz = longint'((mz << 16) / nrm);
    if (dx < 0) tx = -tx;
    if (dy < 0) ty = -ty;
    if (dz < 0) tz = -tz;
    return 1'b1;
  endfunction

  function automatic curv_t predict_curvature(input longint fx, fy, fz);
    longint ex, ey, ez, gx, gy, gz, ax, ay, az, bx, by, bz;
    longint dot, chi, c0, c1, c2, k0, k1v, k2v, d1, d2;
    bit ok_e, ok_f;
    curv_t r;
    r = '0;
    ex = vec_mem[1][0] - vec_mem[0][0];
    ey = vec_mem[1][1] - vec_mem[0][1];
    ez = vec_mem[1][2] - vec_mem[0][2];
    gx = vec_mem[2][0] - vec_mem[1][0];
    gy = vec_mem[2][1] - vec_mem[1][1];
    gz = vec_mem[2][2] - vec_mem[1][2];
    ok_e = unit_dir(ex, ey, ez, ax, ay, az);
    ok_f = unit_dir(gx, gy, gz, bx, by, bz);
    if (!ok_e || !ok_f) begin
      r.deg = 1'b1;
      return r;
    end
    dot = ax * bx + ay * by + az * bz;
    chi = ONE_Q + (dot >>> 16);
    if (chi <= longint'(floor_reg)) begin
      r.deg = 1'b1;
      return r;
    end
    c0 = ay * bz - az * by;
    c1 = az * bx - ax * bz;
    c2 = ax * by - ay * bx;
    k0 = (2 * c0) / chi;
    k1v = (2 * c1) / chi;
    k2v = (2 * c2) / chi;
    if (k0 > KB_MAX) k0 = KB_MAX;
    if (k0 < -KB_MAX) k0 = -KB_MAX;
    if (k1v > KB_MAX) k1v = KB_MAX;
    if (k1v < -KB_MAX) k1v = -KB_MAX;
    if (k2v > KB_MAX) k2v = KB_MAX;
    if (k2v < -KB_MAX) k2v = -KB_MAX;
    d1 = k0 * (vec_mem[4][0] + fx) + k1v * (vec_mem[4][1] + fy)
       + k2v * (vec_mem[4][2] + fz);
    d2 = k0 * (vec_mem[3][0] + vec_mem[5][0])
       + k1v * (vec_mem[3][1] + vec_mem[5][1])
       + k2v * (vec_mem[3][2] + vec_mem[5][2]);
    r.k1 = 24'(sat_q(d1 >>> 17));
    r.k2 = 24'(sat_q((-d2) >>> 17));
    return r;
  endfunction

  always @(posedge clk) begin
    longint vx, vy, vz;
    curv_t want;
    if (rst) begin
      floor_reg = CHI_FLOOR_RESET;
      curv_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) floor_reg = cfg_wdata;
      if (in_valid && in_ready && op != SLOT_NONE) begin
        vx = comp_x; vy = comp_y; vz = comp_z;
        // second directors may arrive with flipped orientation
        if (negate && (op == SLOT_M2E || op == SLOT_M2F)) begin
          vx = sat_q(-vx); vy = sat_q(-vy); vz = sat_q(-vz);
        end
        if (op == SLOT_M2F) begin
          curv_q = {curv_q, predict_curvature(vx, vy, vz)};
        end else begin
          vec_mem[op][0] = vx;
          vec_mem[op][1] = vy;
          vec_mem[op][2] = vz;
        end
      end
      if (out_valid && out_ready) begin
        if (curv_q.size() == 0) begin
          $error("unexpected result word k1=%0d k2=%0d deg=%0d",
                 bend_k1, bend_k2, degenerate);
          errors++;
        end else begin
          want = curv_q.pop_front();
          if (bend_k1 !== want.k1) begin
            $error("bend_k1 exp %0d got %0d", $signed(want.k1), bend_k1);
            errors++;
          end
          if (bend_k2 !== want.k2) begin
            $error("bend_k2 exp %0d got %0d", $signed(want.k2), bend_k2);
            errors++;
          end
          if (degenerate !== want.deg) begin
            $error("degenerate exp %0d got %0d", want.deg, degenerate);
            errors++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_rod_bend_curvature.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rod_bend_curvature
// Drives spring loads into the rod bending curvature block: directed corner
// cases, then random well-formed springs plus noise, over several chi floor
// settings and handshake idling phases. A side checker predicts results.
// ----------------------------------------------------------------------------
module tb_rod_bend_curvature;
  import rbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 700;
  localparam int ITEMS_PER_PHASE = 350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = SLOT_NONE;
  logic signed [23:0] comp_x = '0, comp_y = '0, comp_z = '0;
  logic negate = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] bend_k1, bend_k2;
  logic degenerate;
  int errors, pending;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rod_bend_curvature dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .negate(negate),
    .out_valid(out_valid), .out_ready(out_ready),
    .bend_k1(bend_k1), .bend_k2(bend_k2), .degenerate(degenerate)
  );

  rod_bend_curvature_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .negate(negate),
    .out_valid(out_valid), .out_ready(out_ready),
    .bend_k1(bend_k1), .bend_k2(bend_k2), .degenerate(degenerate),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_word(input logic [2:0] o, input logic [23:0] x, y, z,
                           input logic n);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; comp_x <= x; comp_y <= y; comp_z <= z; negate <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_floor(input logic [15:0] v);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(131071) - 65536);
      3: return 24'h0;
      default: return 24'($urandom());
    endcase
  endfunction

  // one spring: nodes with occasional zero edge or folded back edge
  task automatic send_spring(output int cnt);
    logic [23:0] nx0, ny0, nz0, nx1, ny1, nz1, nx2, ny2, nz2;
    logic [2:0] order [0:5];
    logic [2:0] t;
    int j, k;
    nx0 = rand_comp(); ny0 = rand_comp(); nz0 = rand_comp();
    nx1 = rand_comp(); ny1 = rand_comp(); nz1 = rand_comp();
    nx2 = rand_comp(); ny2 = rand_comp(); nz2 = rand_comp();
    case ($urandom_range(9))
      0: begin nx1 = nx0; ny1 = ny0; nz1 = nz0; end
      1: begin nx2 = nx1; ny2 = ny1; nz2 = nz1; end
      2: begin nx2 = nx0; ny2 = ny0; nz2 = nz0; end
      default: ;
    endcase
    for (j = 0; j < 6; j++) order[j] = 3'(j);
    for (j = 5; j > 0; j--) begin
      k = $urandom_range(j);
      t = order[j]; order[j] = order[k]; order[k] = t;
    end
    cnt = 0;
    for (j = 0; j < 6; j++) begin
      case (order[j])
        SLOT_N0: send_word(SLOT_N0, nx0, ny0, nz0, 1'($urandom_range(1)));
        SLOT_N1: send_word(SLOT_N1, nx1, ny1, nz1, 1'($urandom_range(1)));
        SLOT_N2: send_word(SLOT_N2, nx2, ny2, nz2, 1'($urandom_range(1)));
        default: send_word(order[j], rand_comp(), rand_comp(), rand_comp(),
                           1'($urandom_range(1)));
      endcase
      cnt++;
    end
    send_word(SLOT_M2F, rand_comp(), rand_comp(), rand_comp(),
              1'($urandom_range(1)));
    cnt++;
  endtask

  initial begin
    int phase, sent, n;
    logic [15:0] floors [0:3];
    floors[0] = 16'd0;
    floors[1] = CHI_FLOOR_RESET;
    floors[2] = 16'hFFFF;
    floors[3] = 16'($urandom_range(65535));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    write_floor(16'd0);
    send_word(SLOT_N0, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_word(SLOT_N1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_word(SLOT_N2, 24'h7FFFFF, 24'h800000, 24'h0, 1'b0);
    send_word(SLOT_M1E, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_word(SLOT_M2E, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_word(SLOT_M1F, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_word(SLOT_NONE, 24'h123456, 24'h800000, 24'h7FFFFF, 1'b1);
    send_word(SLOT_M2F, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    // right angle bend, small vectors
    send_word(SLOT_N0, 24'h0, 24'h0, 24'h0, 1'b0);
    send_word(SLOT_N1, 24'h010000, 24'h0, 24'h0, 1'b0);
    send_word(SLOT_N2, 24'h010000, 24'h010000, 24'h0, 1'b0);
    send_word(SLOT_M2F, 24'h0, 24'h0, 24'h010000, 1'b0);
    // zero-length edge
    send_word(SLOT_N1, 24'h0, 24'h0, 24'h0, 1'b0);
    send_word(SLOT_M2F, 24'h0, 24'h0, 24'h010000, 1'b1);
    // edge folded back on itself
    send_word(SLOT_N1, 24'h010000, 24'h0, 24'h0, 1'b0);
    send_word(SLOT_N2, 24'h0, 24'h0, 24'h0, 1'b0);
    send_word(SLOT_M2F, 24'h7FFFFF, 24'h0, 24'h0, 1'b0);
    settle();

    for (phase = 0; phase < 4; phase++) begin
      write_floor(floors[phase]);
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          send_spring(n);
          sent += n;
        end else if ($urandom_range(1)) begin
          send_word(SLOT_NONE, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                    1'($urandom_range(1)));
        end else begin
          send_word(3'($urandom_range(6)), rand_comp(), rand_comp(), rand_comp(),
                    1'($urandom_range(1)));
          sent++;
        end
      end
      settle();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
